// ===== rtl/flxhd_pkg.sv =====
// ============================================================================
// flxhd_pkg: shared types for the Frame Relay / LAPB / X.25 header decoder
// Holds the configuration index codes, the configuration bundle and the
// enumerated frame and packet kinds reported on the result ports.
// ============================================================================
`default_nettype none

package flxhd_pkg;

    // Configuration register indexes on the write channel.
    localparam logic [2:0] CFG_FR_HEADER_PRESENT = 3'd0;
    localparam logic [2:0] CFG_LAYER_ENABLES     = 3'd1;
    localparam logic [2:0] CFG_X25_TYPE_ENABLES  = 3'd2;
    localparam logic [2:0] CFG_DLCI_FILTER       = 3'd3;
    localparam logic [2:0] CFG_LCN_FILTER        = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    // Configuration bundle seen by the decoder.
    typedef struct packed {
        logic        fr_header_present;
        logic [2:0]  layer_enables;
        logic [1:0]  x25_type_enables;
        logic [9:0]  dlci_filter;
        logic [11:0] lcn_filter;
    } cfg_t;

    // LAPB frame kinds.
    typedef enum logic [3:0] {
        LAPB_NONE    = 4'd0,
        LAPB_I       = 4'd1,
        LAPB_RR      = 4'd2,
        LAPB_RNR     = 4'd3,
        LAPB_REJ     = 4'd4,
        LAPB_SABM    = 4'd5,
        LAPB_DM      = 4'd6,
        LAPB_DISC    = 4'd7,
        LAPB_UA      = 4'd8,
        LAPB_FRMR    = 4'd9,
        LAPB_UNKNOWN = 4'd10
    } lapb_kind_t;

    // X.25 packet kinds.
    typedef enum logic [4:0] {
        X25_NONE          = 5'd0,
        X25_DATA          = 5'd1,
        X25_RR            = 5'd2,
        X25_RNR           = 5'd3,
        X25_REJ           = 5'd4,
        X25_CALL_REQ      = 5'd5,
        X25_CALL_ACC      = 5'd6,
        X25_CLEAR_REQ     = 5'd7,
        X25_CLEAR_CONF    = 5'd8,
        X25_INTERRUPT     = 5'd9,
        X25_INTR_CONF     = 5'd10,
        X25_RESET_REQ     = 5'd11,
        X25_RESET_CONF    = 5'd12,
        X25_RESTART_REQ   = 5'd13,
        X25_RESTART_CONF  = 5'd14,
        X25_DIAGNOSTIC    = 5'd15,
        X25_UNKNOWN       = 5'd16
    } x25_kind_t;

    // One decoded result.
    typedef struct packed {
        logic        dlci_match;
        logic [9:0]  dlci;
        logic [5:0]  fr_flag_bits;
        lapb_kind_t  lapb_kind;
        logic [6:0]  lapb_sequence;
        x25_kind_t   x25_kind;
        logic [11:0] logical_channel;
        logic [2:0]  x25_qualifiers;
        logic [6:0]  receive_sequence;
        logic [6:0]  send_sequence;
        logic        more_data;
        logic [15:0] cause_and_diag;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/flxhd_cfg_regs.sv =====
// ============================================================================
// flxhd_cfg_regs: configuration register file
// Takes register writes from the configuration channel and presents the
// current settings as one bundle. Writes to unknown indexes are dropped.
// ============================================================================
`default_nettype none

module flxhd_cfg_regs
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  wr_en,
    input  wire  [flxhd_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  wire  [flxhd_pkg::CFG_DATA_W-1:0]     wr_data,
    output flxhd_pkg::cfg_t                      cfg
);

    flxhd_pkg::cfg_t cfg_reg;
    flxhd_pkg::cfg_t cfg_next;

    // Select the register addressed by a write transfer.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                flxhd_pkg::CFG_FR_HEADER_PRESENT: cfg_next.fr_header_present = wr_data[0];
                flxhd_pkg::CFG_LAYER_ENABLES:     cfg_next.layer_enables     = wr_data[2:0];
                flxhd_pkg::CFG_X25_TYPE_ENABLES:  cfg_next.x25_type_enables  = wr_data[1:0];
                flxhd_pkg::CFG_DLCI_FILTER:       cfg_next.dlci_filter       = wr_data[9:0];
                flxhd_pkg::CFG_LCN_FILTER:        cfg_next.lcn_filter        = wr_data[11:0];
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    // Register state with the documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fr_header_present <= 1'b0;
            cfg_reg.layer_enables     <= 3'b111;
            cfg_reg.x25_type_enables  <= 2'b11;
            cfg_reg.dlci_filter       <= '0;
            cfg_reg.lcn_filter        <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/flxhd_decode.sv =====
// ============================================================================
// flxhd_decode: header field extraction and classification
// Combinational decode of one captured header: Frame Relay address and
// DLCI filter, LAPB control byte, then the X.25 packet header.
// ============================================================================
`default_nettype none

module flxhd_decode
(
    input  flxhd_pkg::cfg_t      cfg,
    input  wire  [63:0]          header_low,
    input  wire  [7:0]           header_byte8,
    input  wire  [15:0]          frame_length,
    output flxhd_pkg::result_t   result
);

    // LAPB control byte patterns (P/F bit masked out for U frames).
    localparam logic [7:0] LAPB_U_MASK = 8'hEF;
    localparam logic [7:0] LAPB_U_SABM = 8'h2F;
    localparam logic [7:0] LAPB_U_DM   = 8'h0F;
    localparam logic [7:0] LAPB_U_DISC = 8'h43;
    localparam logic [7:0] LAPB_U_UA   = 8'h63;
    localparam logic [7:0] LAPB_U_FRMR = 8'h87;
    localparam logic [3:0] LAPB_S_RR   = 4'h1;
    localparam logic [3:0] LAPB_S_RNR  = 4'h5;
    localparam logic [3:0] LAPB_S_REJ  = 4'h9;

    // X.25 packet type identifiers.
    localparam logic [4:0] PT_RR           = 5'h01;
    localparam logic [4:0] PT_RNR          = 5'h05;
    localparam logic [4:0] PT_REJ          = 5'h09;
    localparam logic [7:0] PT_CALL_REQ     = 8'h0B;
    localparam logic [7:0] PT_CALL_ACC     = 8'h0F;
    localparam logic [7:0] PT_CLEAR_REQ    = 8'h13;
    localparam logic [7:0] PT_CLEAR_CONF   = 8'h17;
    localparam logic [7:0] PT_INTERRUPT    = 8'h23;
    localparam logic [7:0] PT_INTR_CONF    = 8'h27;
    localparam logic [7:0] PT_RESET_REQ    = 8'h1B;
    localparam logic [7:0] PT_RESET_CONF   = 8'h1F;
    localparam logic [7:0] PT_RESTART_REQ  = 8'hFB;
    localparam logic [7:0] PT_RESTART_CONF = 8'hFF;
    localparam logic [7:0] PT_DIAGNOSTIC   = 8'hF1;

    localparam logic [9:0]  DLCI_RESERVED = 10'd1023;
    localparam logic [1:0]  GFI_MOD8      = 2'b01;
    localparam logic [15:0] MIN_LAPB_LEN  = 16'd2;
    localparam logic [15:0] MIN_X25_LEN   = 16'd5;
    localparam logic [15:0] FR_ADDR_LEN   = 16'd2;

    logic [7:0]  b0, b1;
    logic [7:0]  c, d0, d1, d2, d3, d4;
    logic [9:0]  dl;
    logic [11:0] lcn;
    logic        mod8;
    logic [6:0]  pr;
    logic        fr_stop;
    logic [15:0] lapb_min, x25_min;
    logic        lapb_ok, x25_ok;
    logic        lcn_pass, type_pass;
    flxhd_pkg::x25_kind_t ctl_kind;

    // Unnumbered frame kind from the control byte.
    function automatic flxhd_pkg::lapb_kind_t lapb_unnumbered(input logic [7:0] ctl);
        logic [7:0] m;
        begin
            m = ctl & LAPB_U_MASK;
            case (m)
                LAPB_U_SABM: lapb_unnumbered = flxhd_pkg::LAPB_SABM;
                LAPB_U_DM:   lapb_unnumbered = flxhd_pkg::LAPB_DM;
                LAPB_U_DISC: lapb_unnumbered = flxhd_pkg::LAPB_DISC;
                LAPB_U_UA:   lapb_unnumbered = flxhd_pkg::LAPB_UA;
                LAPB_U_FRMR: lapb_unnumbered = flxhd_pkg::LAPB_FRMR;
                default:     lapb_unnumbered = flxhd_pkg::LAPB_UNKNOWN;
            endcase
        end
    endfunction

    // Control packet kind from the packet type identifier.
    function automatic flxhd_pkg::x25_kind_t x25_control(input logic [7:0] t);
        begin
            case (t[4:0])
                PT_RR:   x25_control = flxhd_pkg::X25_RR;
                PT_RNR:  x25_control = flxhd_pkg::X25_RNR;
                PT_REJ:  x25_control = flxhd_pkg::X25_REJ;
                default:
                begin
                    case (t)
                        PT_CALL_REQ:     x25_control = flxhd_pkg::X25_CALL_REQ;
                        PT_CALL_ACC:     x25_control = flxhd_pkg::X25_CALL_ACC;
                        PT_CLEAR_REQ:    x25_control = flxhd_pkg::X25_CLEAR_REQ;
                        PT_CLEAR_CONF:   x25_control = flxhd_pkg::X25_CLEAR_CONF;
                        PT_INTERRUPT:    x25_control = flxhd_pkg::X25_INTERRUPT;
                        PT_INTR_CONF:    x25_control = flxhd_pkg::X25_INTR_CONF;
                        PT_RESET_REQ:    x25_control = flxhd_pkg::X25_RESET_REQ;
                        PT_RESET_CONF:   x25_control = flxhd_pkg::X25_RESET_CONF;
                        PT_RESTART_REQ:  x25_control = flxhd_pkg::X25_RESTART_REQ;
                        PT_RESTART_CONF: x25_control = flxhd_pkg::X25_RESTART_CONF;
                        PT_DIAGNOSTIC:   x25_control = flxhd_pkg::X25_DIAGNOSTIC;
                        default:         x25_control = flxhd_pkg::X25_UNKNOWN;
                    endcase
                end
            endcase
        end
    endfunction

    // Byte selection: the LAPB and X.25 bytes shift by two when a Frame Relay
    // address leads the frame.
    always_comb
    begin
        b0 = header_low[7:0];
        b1 = header_low[15:8];
        if (cfg.fr_header_present)
        begin
            c  = header_low[31:24];
            d0 = header_low[39:32];
            d1 = header_low[47:40];
            d2 = header_low[55:48];
            d3 = header_low[63:56];
            d4 = header_byte8;
        end
        else
        begin
            c  = header_low[15:8];
            d0 = header_low[23:16];
            d1 = header_low[31:24];
            d2 = header_low[39:32];
            d3 = header_low[47:40];
            d4 = header_low[55:48];
        end
    end

    // Field extraction and the gating conditions between the layers.
    always_comb
    begin
        dl        = {b0[7:2], b1[7:4]};
        lcn       = {d0[3:0], d1};
        mod8      = (d0[5:4] == GFI_MOD8);
        pr        = mod8 ? {4'b0000, d2[7:5]} : d3[7:1];
        fr_stop   = cfg.fr_header_present &&
                    (((cfg.dlci_filter != '0) && (cfg.dlci_filter != dl)) ||
                     (dl == '0) || (dl == DLCI_RESERVED));
        lapb_min  = cfg.fr_header_present ? (MIN_LAPB_LEN + FR_ADDR_LEN) : MIN_LAPB_LEN;
        x25_min   = cfg.fr_header_present ? (MIN_X25_LEN + FR_ADDR_LEN) : MIN_X25_LEN;
        lapb_ok   = !fr_stop && (frame_length >= lapb_min);
        x25_ok    = lapb_ok && !c[0] && (frame_length >= x25_min);
        lcn_pass  = (cfg.lcn_filter == '0) || (lcn == '0) || (lcn == cfg.lcn_filter);
        type_pass = d2[0] ? cfg.x25_type_enables[1] : cfg.x25_type_enables[0];
        ctl_kind  = x25_control(d2);
    end

    // Assemble the result.
    always_comb
    begin
        result            = '0;
        result.dlci_match = 1'b1;

        // Frame Relay address and DLCI filter.
        if (cfg.fr_header_present)
        begin
            if (cfg.layer_enables[0])
            begin
                result.dlci         = dl;
                result.fr_flag_bits = {b0[1], b0[0], b1[3], b1[2], b1[1], b1[0]};
            end
            if ((cfg.dlci_filter != '0) && (cfg.dlci_filter != dl))
            begin
                result.dlci_match = 1'b0;
            end
        end

        // LAPB control byte.
        if (lapb_ok && cfg.layer_enables[1])
        begin
            if (!c[0])
            begin
                result.lapb_kind     = flxhd_pkg::LAPB_I;
                result.lapb_sequence = {c[4], c[7:5], c[3:1]};
            end
            else if (c[3:0] == LAPB_S_RR)
            begin
                result.lapb_kind     = flxhd_pkg::LAPB_RR;
                result.lapb_sequence = {c[4], c[7:5], 3'b000};
            end
            else if (c[3:0] == LAPB_S_RNR)
            begin
                result.lapb_kind     = flxhd_pkg::LAPB_RNR;
                result.lapb_sequence = {c[4], c[7:5], 3'b000};
            end
            else if (c[3:0] == LAPB_S_REJ)
            begin
                result.lapb_kind     = flxhd_pkg::LAPB_REJ;
                result.lapb_sequence = {c[4], c[7:5], 3'b000};
            end
            else
            begin
                result.lapb_kind = lapb_unnumbered(c);
                if (result.lapb_kind != flxhd_pkg::LAPB_UNKNOWN)
                begin
                    result.lapb_sequence = {c[4], 6'b000000};
                end
            end
        end

        // X.25 packet header of an I-frame.
        if (x25_ok && cfg.layer_enables[2] && lcn_pass && type_pass)
        begin
            result.logical_channel = lcn;
            result.x25_qualifiers  = {!mod8, d0[6], d0[7]};
            if (!d2[0])
            begin
                result.x25_kind         = flxhd_pkg::X25_DATA;
                result.receive_sequence = pr;
                if (mod8)
                begin
                    result.send_sequence = {4'b0000, d2[3:1]};
                    result.more_data     = d2[4];
                end
                else
                begin
                    result.send_sequence = d2[7:1];
                    result.more_data     = d3[0];
                end
            end
            else
            begin
                result.x25_kind = ctl_kind;
                if ((ctl_kind == flxhd_pkg::X25_RR) || (ctl_kind == flxhd_pkg::X25_RNR) ||
                    (ctl_kind == flxhd_pkg::X25_REJ))
                begin
                    result.receive_sequence = pr;
                end
                if ((ctl_kind == flxhd_pkg::X25_CLEAR_REQ) ||
                    (ctl_kind == flxhd_pkg::X25_CLEAR_CONF) ||
                    (ctl_kind == flxhd_pkg::X25_RESET_REQ) ||
                    (ctl_kind == flxhd_pkg::X25_RESTART_REQ))
                begin
                    result.cause_and_diag = {d3, d4};
                end
                else if (ctl_kind == flxhd_pkg::X25_INTERRUPT)
                begin
                    result.cause_and_diag = {d3, 8'h00};
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fr_lapb_x25_header_decoder.sv =====
// ============================================================================
// fr_lapb_x25_header_decoder: X.25 over LAPB header decoder
// Decodes an optional Frame Relay address, the LAPB control byte and the
// X.25 packet header of one captured frame per clock.
// ============================================================================
// Usage:
//   Command channel: raise start with header_low, header_byte8 and
//   frame_length; the header is taken at any clock edge where start is high
//   and busy is low. busy is always low, so a header may be issued on every
//   cycle.
//   Result channel: after the input and result registers, result_valid is high
//   for exactly one cycle with the decoded fields. One result per header,
//   in issue order. The receiver cannot stall; results must be captured in
//   the strobe cycle. The result fields hold their last value otherwise.
//   Configuration channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high, so each write is one transfer. Change settings
//   only while no header is in flight.
//   The pipeline is input register, decode, result register, and
//   throughput is one header per cycle, set by the single decode stage.
//   Reset (rst_n low) clears the pipeline valid flags and loads the default
//   settings: no Frame Relay header, all layers and packet types enabled,
//   both filters open.
// ============================================================================
`default_nettype none

module fr_lapb_x25_header_decoder
(
    input  wire                                clk,
    input  wire                                rst_n,
    // Command channel
    input  wire                                start,
    output logic                               busy,
    input  wire  [63:0]                        header_low,
    input  wire  [7:0]                         header_byte8,
    input  wire  [15:0]                        frame_length,
    // Configuration channel
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [flxhd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [flxhd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Result channel
    output logic                               result_valid,
    output logic                               dlci_match,
    output logic [9:0]                         dlci,
    output logic [5:0]                         fr_flag_bits,
    output logic [3:0]                         lapb_kind,
    output logic [6:0]                         lapb_sequence,
    output logic [4:0]                         x25_kind,
    output logic [11:0]                        logical_channel,
    output logic [2:0]                         x25_qualifiers,
    output logic [6:0]                         receive_sequence,
    output logic [6:0]                         send_sequence,
    output logic                               more_data,
    output logic [15:0]                        cause_and_diag
);

    flxhd_pkg::cfg_t    cfg;
    flxhd_pkg::result_t dec_result;
    flxhd_pkg::result_t result_reg;
    logic               result_valid_reg;
    logic               in_valid_reg;
    logic [63:0]        header_low_reg;
    logic [7:0]         header_byte8_reg;
    logic [15:0]        frame_length_reg;
    logic               accept;

    // Handshakes: the pipeline never stalls.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers.
    flxhd_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Input stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            header_low_reg   <= header_low;
            header_byte8_reg <= header_byte8;
            frame_length_reg <= frame_length;
        end
    end

    // Decode stage.
    flxhd_decode u_decode
    (
        .cfg          (cfg),
        .header_low   (header_low_reg),
        .header_byte8 (header_byte8_reg),
        .frame_length (frame_length_reg),
        .result       (dec_result)
    );

    // Result stage strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= in_valid_reg;
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= dec_result;
        end
    end

    // Output ports.
    assign result_valid     = result_valid_reg;
    assign dlci_match       = result_reg.dlci_match;
    assign dlci             = result_reg.dlci;
    assign fr_flag_bits     = result_reg.fr_flag_bits;
    assign lapb_kind        = result_reg.lapb_kind;
    assign lapb_sequence    = result_reg.lapb_sequence;
    assign x25_kind         = result_reg.x25_kind;
    assign logical_channel  = result_reg.logical_channel;
    assign x25_qualifiers   = result_reg.x25_qualifiers;
    assign receive_sequence = result_reg.receive_sequence;
    assign send_sequence    = result_reg.send_sequence;
    assign more_data        = result_reg.more_data;
    assign cause_and_diag   = result_reg.cause_and_diag;

endmodule

`default_nettype wire

// ===== rtl/flxhd_checker.sv =====
// ============================================================================
// flxhd_checker: port-level checks for the header decoder
// Watches the top-level ports for result timing and for consistency
// between the reported layer kinds and their fields.
// ============================================================================
`default_nettype none

module flxhd_checker
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire         busy,
    input  wire         result_valid,
    input  wire         dlci_match,
    input  wire  [3:0]  lapb_kind,
    input  wire  [6:0]  lapb_sequence,
    input  wire  [4:0]  x25_kind,
    input  wire  [11:0] logical_channel,
    input  wire  [2:0]  x25_qualifiers,
    input  wire  [6:0]  receive_sequence,
    input  wire  [6:0]  send_sequence,
    input  wire         more_data,
    input  wire  [15:0] cause_and_diag
);

    // Every header transfer yields a result strobe, through the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 result_valid)
    else $error("result strobe missing two cycles after a header transfer");

    // A result strobe only follows a header transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 2))
    else $error("result strobe without a matching header transfer");

    // A frame dropped by the DLCI filter carries no LAPB or X.25 decode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !dlci_match) |->
            (lapb_kind == flxhd_pkg::LAPB_NONE) && (x25_kind == flxhd_pkg::X25_NONE))
    else $error("dropped frame reports LAPB or X.25 fields");

    // No LAPB kind means no LAPB sequence fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (lapb_kind == flxhd_pkg::LAPB_NONE)) |-> (lapb_sequence == '0))
    else $error("LAPB sequence reported without a LAPB kind");

    // No X.25 kind means every X.25 field is clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (x25_kind == flxhd_pkg::X25_NONE)) |->
            (logical_channel == '0) && (x25_qualifiers == '0) &&
            (receive_sequence == '0) && (send_sequence == '0) &&
            !more_data && (cause_and_diag == '0))
    else $error("X.25 fields reported without an X.25 kind");

endmodule

bind fr_lapb_x25_header_decoder flxhd_checker u_flxhd_checker (.*);

`default_nettype wire

// ===== tb/flxhd_tb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// flxhd_tb_pkg: protocol codes and scoreboard for the header decoder bench
// Holds the LAPB and X.25 byte codes used to build frames, and a scoreboard
// that decodes each accepted header on its own and checks the results.
// ============================================================================

package flxhd_tb_pkg;

    import flxhd_pkg::*;

    // LAPB supervisory codes, low nibble of the control byte.
    localparam logic [3:0] S_RR  = 4'h1;
    localparam logic [3:0] S_RNR = 4'h5;
    localparam logic [3:0] S_REJ = 4'h9;

    // LAPB unnumbered codes, with the P/F bit cleared.
    localparam logic [7:0] U_SABM       = 8'h2F;
    localparam logic [7:0] U_DM         = 8'h0F;
    localparam logic [7:0] U_DISC       = 8'h43;
    localparam logic [7:0] U_UA         = 8'h63;
    localparam logic [7:0] U_FRMR       = 8'h87;
    localparam logic [7:0] U_UNASSIGNED = 8'h03;
    localparam logic [7:0] U_PF_BIT     = 8'h10;
    localparam logic [7:0] U_PF_MASK    = 8'hEF;

    // X.25 flow control codes, low five bits of the packet type.
    localparam logic [4:0] PT_RR  = 5'h01;
    localparam logic [4:0] PT_RNR = 5'h05;
    localparam logic [4:0] PT_REJ = 5'h09;

    // X.25 packet type bytes matched in full.
    localparam logic [7:0] PT_CALL_REQ     = 8'h0B;
    localparam logic [7:0] PT_CALL_ACC     = 8'h0F;
    localparam logic [7:0] PT_CLEAR_REQ    = 8'h13;
    localparam logic [7:0] PT_CLEAR_CONF   = 8'h17;
    localparam logic [7:0] PT_INTERRUPT    = 8'h23;
    localparam logic [7:0] PT_INTR_CONF    = 8'h27;
    localparam logic [7:0] PT_RESET_REQ    = 8'h1B;
    localparam logic [7:0] PT_RESET_CONF   = 8'h1F;
    localparam logic [7:0] PT_RESTART_REQ  = 8'hFB;
    localparam logic [7:0] PT_RESTART_CONF = 8'hFF;
    localparam logic [7:0] PT_DIAGNOSTIC   = 8'hF1;
    localparam logic [7:0] PT_UNASSIGNED   = 8'h03;

    // GFI modulo bits and the reserved DLCI at the top of the range.
    localparam logic [1:0] GFI_MOD8         = 2'b01;
    localparam logic [1:0] GFI_MOD128       = 2'b10;
    localparam logic [9:0] DLCI_RESERVED_HI = 10'h3FF;

    // Control byte for a non-I LAPB frame: 0..2 supervisory, 3..7 unnumbered,
    // anything else an unassigned code. Free bits come from noise.
    function automatic logic [7:0] lapb_ctl_pick(int k, logic [7:0] noise);
        case (k)
            0: return {noise[7:4], S_RR};
            1: return {noise[7:4], S_RNR};
            2: return {noise[7:4], S_REJ};
            3: return U_SABM | (noise & U_PF_BIT);
            4: return U_DM | (noise & U_PF_BIT);
            5: return U_DISC | (noise & U_PF_BIT);
            6: return U_UA | (noise & U_PF_BIT);
            7: return U_FRMR | (noise & U_PF_BIT);
            default: return U_UNASSIGNED | (noise & U_PF_BIT);
        endcase
    endfunction

    // Packet type byte of an X.25 control packet: 0..13 the known types in
    // kind order, anything else an unassigned code.
    function automatic logic [7:0] x25_ctl_pick(int k, logic [7:0] noise);
        case (k)
            0: return {noise[7:5], PT_RR};
            1: return {noise[7:5], PT_RNR};
            2: return {noise[7:5], PT_REJ};
            3: return PT_CALL_REQ;
            4: return PT_CALL_ACC;
            5: return PT_CLEAR_REQ;
            6: return PT_CLEAR_CONF;
            7: return PT_INTERRUPT;
            8: return PT_INTR_CONF;
            9: return PT_RESET_REQ;
            10: return PT_RESET_CONF;
            11: return PT_RESTART_REQ;
            12: return PT_RESTART_CONF;
            13: return PT_DIAGNOSTIC;
            default: return PT_UNASSIGNED;
        endcase
    endfunction

    class decode_scoreboard;

        // Shadow copy of the decoder settings.
        logic        fr_present;
        logic [2:0]  layers;
        logic [1:0]  type_en;
        logic [9:0]  dlci_sel;
        logic [11:0] lcn_sel;

        result_t expected_headers[$];
        int      errors;

        function new();
            fr_present = 1'b0;
            layers     = 3'd7;
            type_en    = 2'd3;
            dlci_sel   = '0;
            lcn_sel    = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_FR_HEADER_PRESENT: fr_present = data[0];
                CFG_LAYER_ENABLES:     layers     = data[2:0];
                CFG_X25_TYPE_ENABLES:  type_en    = data[1:0];
                CFG_DLCI_FILTER:       dlci_sel   = data[9:0];
                CFG_LCN_FILTER:        lcn_sel    = data[11:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_headers.size();
        endfunction

        // Decode one captured header under the current settings.
        function result_t decode_header(logic [63:0] lo, logic [7:0] b8, logic [15:0] flen);
            result_t    r;
            logic [7:0] hb [9];
            logic [7:0] ctl, d0, d1, d2, d3, d4;
            logic [9:0] dl;
            logic [11:0] lcn;
            logic [6:0] pr;
            logic       mod8, go_on, stop, report;
            x25_kind_t  kind;
            int         len, off;

            r = '0;
            r.dlci_match = 1'b1;
            for (int i = 0; i < 8; i++)
                hb[i] = lo[8*i +: 8];
            hb[8] = b8;
            len  = int'(flen);
            off  = 0;
            stop = 1'b0;

            // Frame Relay address: fields are shown even for a dropped frame.
            if (fr_present) begin
                dl = {hb[0][7:2], hb[1][7:4]};
                if (layers[0]) begin
                    r.dlci = dl;
                    r.fr_flag_bits = {hb[0][1:0], hb[1][3:0]};
                end
                if (dlci_sel != '0 && dlci_sel != dl) begin
                    r.dlci_match = 1'b0;
                    stop = 1'b1;
                end
                else begin
                    off = 2;
                    len -= 2;
                    if (dl == '0 || dl == DLCI_RESERVED_HI)
                        stop = 1'b1;
                end
            end
            if (!stop && len < 2)
                stop = 1'b1;

            // LAPB control byte. Only I-frames carry on to X.25.
            if (!stop) begin
                ctl = hb[off + 1];
                if (layers[1]) begin
                    go_on = 1'b0;
                    if (!ctl[0]) begin
                        r.lapb_kind = LAPB_I;
                        r.lapb_sequence = {ctl[4], ctl[7:5], ctl[3:1]};
                        go_on = (len >= 5);
                    end
                    else if (ctl[3:0] == S_RR || ctl[3:0] == S_RNR || ctl[3:0] == S_REJ) begin
                        r.lapb_kind = (ctl[3:0] == S_RR)  ? LAPB_RR :
                                      (ctl[3:0] == S_RNR) ? LAPB_RNR : LAPB_REJ;
                        r.lapb_sequence = {ctl[4], ctl[7:5], 3'd0};
                    end
                    else begin
                        case (ctl & U_PF_MASK)
                            U_SABM:  r.lapb_kind = LAPB_SABM;
                            U_DM:    r.lapb_kind = LAPB_DM;
                            U_DISC:  r.lapb_kind = LAPB_DISC;
                            U_UA:    r.lapb_kind = LAPB_UA;
                            U_FRMR:  r.lapb_kind = LAPB_FRMR;
                            default: r.lapb_kind = LAPB_UNKNOWN;
                        endcase
                        r.lapb_sequence = (r.lapb_kind == LAPB_UNKNOWN) ? 7'd0 : {ctl[4], 6'd0};
                    end
                end
                else begin
                    go_on = !ctl[0];
                end
                if (!go_on)
                    stop = 1'b1;
                else begin
                    len -= 2;
                    if (len < 3)
                        stop = 1'b1;
                end
            end

            // X.25 packet header, subject to the LCN and packet type filters.
            if (!stop && layers[2]) begin
                d0   = hb[off + 2];
                d1   = hb[off + 3];
                d2   = hb[off + 4];
                d3   = hb[off + 5];
                d4   = hb[off + 6];
                lcn  = {d0[3:0], d1};
                mod8 = (d0[5:4] == GFI_MOD8);
                pr   = mod8 ? {4'd0, d2[7:5]} : d3[7:1];
                report = 1'b1;
                if (lcn_sel != '0 && lcn != '0 && lcn != lcn_sel)
                    report = 1'b0;
                if (d2[0] ? !type_en[1] : !type_en[0])
                    report = 1'b0;
                if (report) begin
                    r.logical_channel = lcn;
                    r.x25_qualifiers = {!mod8, d0[6], d0[7]};
                    if (!d2[0]) begin
                        r.x25_kind = X25_DATA;
                        r.receive_sequence = pr;
                        r.send_sequence = mod8 ? {4'd0, d2[3:1]} : d2[7:1];
                        r.more_data = mod8 ? d2[4] : d3[0];
                    end
                    else begin
                        if (d2[4:0] == PT_RR)
                            kind = X25_RR;
                        else if (d2[4:0] == PT_RNR)
                            kind = X25_RNR;
                        else if (d2[4:0] == PT_REJ)
                            kind = X25_REJ;
                        else begin
                            case (d2)
                                PT_CALL_REQ:     kind = X25_CALL_REQ;
                                PT_CALL_ACC:     kind = X25_CALL_ACC;
                                PT_CLEAR_REQ:    kind = X25_CLEAR_REQ;
                                PT_CLEAR_CONF:   kind = X25_CLEAR_CONF;
                                PT_INTERRUPT:    kind = X25_INTERRUPT;
                                PT_INTR_CONF:    kind = X25_INTR_CONF;
                                PT_RESET_REQ:    kind = X25_RESET_REQ;
                                PT_RESET_CONF:   kind = X25_RESET_CONF;
                                PT_RESTART_REQ:  kind = X25_RESTART_REQ;
                                PT_RESTART_CONF: kind = X25_RESTART_CONF;
                                PT_DIAGNOSTIC:   kind = X25_DIAGNOSTIC;
                                default:         kind = X25_UNKNOWN;
                            endcase
                        end
                        r.x25_kind = kind;
                        if (kind == X25_RR || kind == X25_RNR || kind == X25_REJ)
                            r.receive_sequence = pr;
                        if (kind == X25_CLEAR_REQ || kind == X25_CLEAR_CONF ||
                            kind == X25_RESET_REQ || kind == X25_RESTART_REQ)
                            r.cause_and_diag = {d3, d4};
                        else if (kind == X25_INTERRUPT)
                            r.cause_and_diag = {d3, 8'd0};
                    end
                end
            end
            return r;
        endfunction

        function void note_header(logic [63:0] lo, logic [7:0] b8, logic [15:0] flen);
            expected_headers.push_back(decode_header(lo, b8, flen));
        endfunction

        function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
            if (act_val !== exp_val) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        // Check one result against the oldest decoded header.
        function void check_result(result_t got);
            result_t want;
            if (expected_headers.size() == 0) begin
                $error("result transfer with no header outstanding");
                errors++;
                return;
            end
            want = expected_headers.pop_front();
            compare_field("dlci_match", 16'(want.dlci_match), 16'(got.dlci_match));
            compare_field("dlci", 16'(want.dlci), 16'(got.dlci));
            compare_field("fr_flag_bits", 16'(want.fr_flag_bits), 16'(got.fr_flag_bits));
            compare_field("lapb_kind", 16'(want.lapb_kind), 16'(got.lapb_kind));
            compare_field("lapb_sequence", 16'(want.lapb_sequence), 16'(got.lapb_sequence));
            compare_field("x25_kind", 16'(want.x25_kind), 16'(got.x25_kind));
            compare_field("logical_channel", 16'(want.logical_channel),
                          16'(got.logical_channel));
            compare_field("x25_qualifiers", 16'(want.x25_qualifiers),
                          16'(got.x25_qualifiers));
            compare_field("receive_sequence", 16'(want.receive_sequence),
                          16'(got.receive_sequence));
            compare_field("send_sequence", 16'(want.send_sequence), 16'(got.send_sequence));
            compare_field("more_data", 16'(want.more_data), 16'(got.more_data));
            compare_field("cause_and_diag", want.cause_and_diag, got.cause_and_diag);
        endfunction

    endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: bench for the Frame Relay / LAPB / X.25 header decoder
// Drives directed headers and then random, mostly well-formed frames in
// bursts under a series of settings, and checks every result field against
// a decode done by the scoreboard.
// ============================================================================

module tb_top;

    import flxhd_pkg::*;
    import flxhd_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] header_low;
    logic [7:0]  header_byte8;
    logic [15:0] frame_length;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic        result_valid;
    logic        dlci_match;
    logic [9:0]  dlci;
    logic [5:0]  fr_flag_bits;
    logic [3:0]  lapb_kind;
    logic [6:0]  lapb_sequence;
    logic [4:0]  x25_kind;
    logic [11:0] logical_channel;
    logic [2:0]  x25_qualifiers;
    logic [6:0]  receive_sequence;
    logic [6:0]  send_sequence;
    logic        more_data;
    logic [15:0] cause_and_diag;

    decode_scoreboard sb;

    fr_lapb_x25_header_decoder u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .header_low       (header_low),
        .header_byte8     (header_byte8),
        .frame_length     (frame_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .dlci_match       (dlci_match),
        .dlci             (dlci),
        .fr_flag_bits     (fr_flag_bits),
        .lapb_kind        (lapb_kind),
        .lapb_sequence    (lapb_sequence),
        .x25_kind         (x25_kind),
        .logical_channel  (logical_channel),
        .x25_qualifiers   (x25_qualifiers),
        .receive_sequence (receive_sequence),
        .send_sequence    (send_sequence),
        .more_data        (more_data),
        .cause_and_diag   (cause_and_diag)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #2ms;
        $display("tb_top: errors");
        $finish;
    end

    // Result monitor: each strobe is one transfer, checked at its closing edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid !== 1'b0)
            sb.check_result({dlci_match, dlci, fr_flag_bits, lapb_kind, lapb_sequence,
                             x25_kind, logical_channel, x25_qualifiers, receive_sequence,
                             send_sequence, more_data, cause_and_diag});
    end

    // Present one header and hold it until the decoder takes it.
    task automatic send_header(input logic [63:0] lo, input logic [7:0] b8,
                               input logic [15:0] flen);
        start        <= 1'b1;
        header_low   <= lo;
        header_byte8 <= b8;
        frame_length <= flen;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_header(lo, b8, flen);
    endtask

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic wait_drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write all five registers back to back; only called with nothing in flight.
    task automatic apply_settings(input logic fr, input logic [2:0] le, input logic [1:0] te,
                                  input logic [9:0] dl, input logic [11:0] lf);
        logic [CFG_DATA_W-1:0]  value [5];
        logic [CFG_INDEX_W-1:0] index [5];
        index[0] = CFG_FR_HEADER_PRESENT;
        value[0] = {{(CFG_DATA_W-1){1'b0}}, fr};
        index[1] = CFG_LAYER_ENABLES;
        value[1] = {{(CFG_DATA_W-3){1'b0}}, le};
        index[2] = CFG_X25_TYPE_ENABLES;
        value[2] = {{(CFG_DATA_W-2){1'b0}}, te};
        index[3] = CFG_DLCI_FILTER;
        value[3] = {{(CFG_DATA_W-10){1'b0}}, dl};
        index[4] = CFG_LCN_FILTER;
        value[4] = lf;
        for (int k = 0; k < 5; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= index[k];
            cfg_data  <= value[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_reg(index[k], value[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random frames in bursts, shaped by the current settings so that most
    // get through the address and LAPB stages into the X.25 decode.
    task automatic run_random(input int count);
        logic [7:0]  hb [9];
        logic [63:0] lo;
        logic [15:0] flen;
        logic [9:0]  dl;
        logic [11:0] lcn;
        int          off, burst, pick;
        burst = $urandom_range(1, 12);
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 9; i++)
                hb[i] = 8'($urandom_range(0, 255));
            off = sb.fr_present ? 2 : 0;

            // DLCI: mostly the filtered one, sometimes reserved or random.
            if (sb.fr_present)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6 && sb.dlci_sel != '0)
                    dl = sb.dlci_sel;
                else if (pick == 6)
                    dl = '0;
                else if (pick == 7)
                    dl = DLCI_RESERVED_HI;
                else
                    dl = 10'($urandom_range(0, 1023));
                hb[0][7:2] = dl[9:4];
                hb[1][7:4] = dl[3:0];
            end

            // LAPB control: mostly I-frames.
            pick = $urandom_range(0, 9);
            if (pick < 6)
                hb[off + 1][0] = 1'b0;
            else if (pick < 8)
                hb[off + 1] = lapb_ctl_pick($urandom_range(0, 8), hb[off + 1]);

            // X.25 header: GFI, channel and packet type.
            if ($urandom_range(0, 3) != 0)
                hb[off + 2][5:4] = $urandom_range(0, 1) ? GFI_MOD8 : GFI_MOD128;
            pick = $urandom_range(0, 3);
            if (pick < 2 && sb.lcn_sel != '0)
                lcn = sb.lcn_sel;
            else if (pick == 2)
                lcn = '0;
            else
                lcn = 12'($urandom_range(0, 4095));
            hb[off + 2][3:0] = lcn[11:8];
            hb[off + 3] = lcn[7:0];
            pick = $urandom_range(0, 9);
            if (pick < 4)
                hb[off + 4][0] = 1'b0;
            else if (pick < 9)
                hb[off + 4] = x25_ctl_pick($urandom_range(0, 13), hb[off + 4]);

            // Length: mostly long enough for a full decode.
            pick = $urandom_range(0, 9);
            if (pick < 8)
                flen = 16'($urandom_range(off + 5, 200));
            else if (pick == 8)
                flen = 16'($urandom_range(0, 8));
            else
                flen = 16'($urandom_range(0, 65535));

            for (int i = 0; i < 8; i++)
                lo[8*i +: 8] = hb[i];
            send_header(lo, hb[8], flen);

            // Burst bookkeeping, with an occasional full drain.
            burst--;
            if (burst == 0)
            begin
                if ($urandom_range(0, 29) == 0)
                    wait_drain();
                else
                    idle_for($urandom_range(1, 8));
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            end
        end
        wait_drain();
    endtask

    // Main sequence.
    initial
    begin
        logic [63:0] lo;
        sb = new();
        rst_n        <= 1'b0;
        start        <= 1'b0;
        header_low   <= '0;
        header_byte8 <= '0;
        frame_length <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings, no Frame Relay address.
        // All zeros: an I-frame one byte too short for X.25.
        send_header('0, '0, 16'd4);
        // All ones at the longest length.
        send_header('1, 8'hFF, 16'hFFFF);
        // Each supervisory and unnumbered LAPB kind, plus an unassigned one.
        for (int k = 0; k < 9; k++)
        begin
            lo = {$urandom, $urandom};
            lo[15:8] = lapb_ctl_pick(k, lo[15:8]);
            send_header(lo, 8'($urandom_range(0, 255)), 16'd20);
        end
        // Data packets, modulo 8 at the shortest decodable length and modulo 128.
        lo = {$urandom, $urandom};
        lo[8] = 1'b0;
        lo[21:20] = GFI_MOD8;
        lo[32] = 1'b0;
        send_header(lo, 8'($urandom_range(0, 255)), 16'd5);
        lo = {$urandom, $urandom};
        lo[8] = 1'b0;
        lo[21:20] = GFI_MOD128;
        lo[32] = 1'b0;
        send_header(lo, 8'($urandom_range(0, 255)), 16'd9);
        // Each control packet type, then an unassigned type.
        for (int k = 0; k < 15; k++)
        begin
            lo = {$urandom, $urandom};
            lo[8] = 1'b0;
            lo[21:20] = k[0] ? GFI_MOD128 : GFI_MOD8;
            lo[39:32] = x25_ctl_pick(k, lo[39:32]);
            send_header(lo, 8'($urandom_range(0, 255)), 16'd12);
        end
        wait_drain();

        // Random part across a range of settings, extremes included.
        apply_settings(1'b1, 3'd7, 2'd3, 10'd0, 12'd0);
        run_random(70);
        apply_settings(1'b1, 3'd7, 2'd3, 10'($urandom_range(1, 1022)),
                       12'($urandom_range(1, 4095)));
        run_random(70);
        apply_settings(1'b1, 3'd5, 2'd1, 10'h3FF, 12'hFFF);
        run_random(60);
        apply_settings(1'b0, 3'd0, 2'd0, 10'd0, 12'd0);
        run_random(40);
        apply_settings(1'b0, 3'd6, 2'd2, 10'($urandom_range(0, 1023)),
                       12'($urandom_range(1, 4095)));
        run_random(60);
        repeat (5)
        begin
            apply_settings(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                           2'($urandom_range(0, 3)),
                           $urandom_range(0, 1) ? 10'd0 : 10'($urandom_range(1, 1023)),
                           $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(1, 4095)));
            run_random(60);
        end

        // Final settle, then the verdict.
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
